FILE: src/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants for the launch speed pipeline.
// Holds the sideband record and the fixed-point constants shared by the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kls_pkg;

  localparam int DistW  = 20;
  localparam int SpeedW = 20;
  localparam int DecelW = 14;
  localparam int RadW   = 40;
  localparam int RemW   = 23;

  localparam logic [1:0] BandNear = 2'd0;
  localparam logic [1:0] BandMid  = 2'd1;
  localparam logic [1:0] BandFar  = 2'd2;

  typedef struct packed {
    logic [DistW-1:0]  pass_len;
    logic [1:0]        band;
    logic [DecelW-1:0] acc;
  } kls_side_t;

  function automatic logic [RadW-1:0] band_vt2(input logic [1:0] band);
    logic [RadW-1:0] r;
    case (band)
      BandNear: r = 40'd3171942400;
      BandMid:  r = 40'd5898240000;
      default:  r = 40'd13271040000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/kick_launch_speed.sv
// ----------------------------------------------------------------------------
// kick_launch_speed: launch speed needed for a pass of a given distance.
// A row of square root and deceleration cells refines the speed estimate.
//
//   port group   dir  contents (low bit first)
//   s_axis_*     in   distance[19:0]
//   m_axis_*     out  launch_speed[19:0], final_decel[33:20]
//
// One distance enters per cycle unless the row holds; between a distance
// and its result lie the input register, the 20 root cells of each square
// root and two deceleration registers per refinement. The whole row advances
// together and holds while a result waits and m_axis_tready is low. Reset
// empties the row; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kick_launch_speed
  import kls_pkg::*;
#(
  parameter int REFINE_STEPS = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // distance[19:0], zero fill
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // launch_speed[19:0], final_decel[33:20]
);

  logic              en;
  logic [DistW-1:0]  pass_len;
  logic [1:0]        band;
  kls_side_t         side0;
  logic [RadW-1:0]   rad0_d;
  logic              v0_q;
  logic [RadW-1:0]   rad0_q;
  kls_side_t         side0_q;

  logic              sv   [REFINE_STEPS+1];
  logic [SpeedW-1:0] sroot[REFINE_STEPS+1];
  kls_side_t         sside[REFINE_STEPS+1];
  logic              dv   [REFINE_STEPS];
  logic [RadW-1:0]   drad [REFINE_STEPS];
  kls_side_t         dside[REFINE_STEPS];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign pass_len = s_axis_tdata[DistW-1:0];
  assign band = (pass_len < 20'd1600) ? BandNear :
                ((pass_len < 20'd3200) ? BandMid : BandFar);
  assign side0.pass_len = pass_len;
  assign side0.band     = band;
  assign side0.acc      = '0;
  assign rad0_d = band_vt2(band) +
                  {2'b0, ({1'b0, pass_len, 5'b0} + {3'b0, pass_len, 3'b0}), 12'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad0_q  <= rad0_d;
      side0_q <= side0;
    end
  end

  kls_sqrt_chain u_sqrt0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .rad_i   (rad0_q),
    .side_i  (side0_q),
    .valid_o (sv[0]),
    .root_o  (sroot[0]),
    .side_o  (sside[0])
  );

  for (genvar r = 0; r < REFINE_STEPS; r++) begin : g_refine
    kls_decel_cell u_decel (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[r]),
      .speed_i (sroot[r]),
      .side_i  (sside[r]),
      .valid_o (dv[r]),
      .rad_o   (drad[r]),
      .side_o  (dside[r])
    );
    kls_sqrt_chain u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[r]),
      .rad_i   (drad[r]),
      .side_i  (dside[r]),
      .valid_o (sv[r+1]),
      .root_o  (sroot[r+1]),
      .side_o  (sside[r+1])
    );
  end

  assign m_axis_tvalid = sv[REFINE_STEPS];
  assign m_axis_tdata  = {6'b0, sside[REFINE_STEPS].acc, sroot[REFINE_STEPS]};

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  a_decel_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[33:20] >= 14'd2560))
    else $error("final deceleration below its lowest reachable value");

  a_speed_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19:0] >= 20'd56320))
    else $error("launch speed below the slowest target speed");
`endif

endmodule
`default_nettype wire

FILE: src/kls_sqrt_cell.sv
// ----------------------------------------------------------------------------
// kls_sqrt_cell: one bit of a pipelined integer square root.
// Brings down two radicand bits, tries the next root bit and registers it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kls_sqrt_cell
  import kls_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [RemW-1:0]   rem_i,
  input  wire logic [SpeedW-1:0] root_i,
  input  wire logic [RadW-1:0]   rad_i,
  input  wire kls_side_t         side_i,
  output logic                   valid_o,
  output logic [RemW-1:0]        rem_o,
  output logic [SpeedW-1:0]      root_o,
  output logic [RadW-1:0]        rad_o,
  output kls_side_t              side_o
);

  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;
  logic              take;
  logic [RemW-1:0]   rem_d;
  logic [SpeedW-1:0] root_d;
  logic              valid_q;
  logic [RemW-1:0]   rem_q;
  logic [SpeedW-1:0] root_q;
  logic [RadW-1:0]   rad_q;
  kls_side_t         side_q;

  assign rem_sh = {rem_i[RemW-3:0], rad_i[RadW-1 -: 2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign take   = (rem_sh >= trial);
  assign rem_d  = take ? (rem_sh - trial) : rem_sh;
  assign root_d = {root_i[SpeedW-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= {rad_i[RadW-3:0], 2'b00};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

FILE: src/kls_sqrt_chain.sv
// ----------------------------------------------------------------------------
// kls_sqrt_chain: a row of square root cells, one root bit per cell.
// Turns a 40-bit radicand into its 20-bit floor root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kls_sqrt_chain
  import kls_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [RadW-1:0]   rad_i,
  input  wire kls_side_t         side_i,
  output logic                   valid_o,
  output logic [SpeedW-1:0]      root_o,
  output kls_side_t              side_o
);

  logic              valid_w [SpeedW+1];
  logic [RemW-1:0]   rem_w   [SpeedW+1];
  logic [SpeedW-1:0] root_w  [SpeedW+1];
  logic [RadW-1:0]   rad_w   [SpeedW+1];
  kls_side_t         side_w  [SpeedW+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = '0;
  assign root_w[0]  = '0;
  assign rad_w[0]   = rad_i;
  assign side_w[0]  = side_i;

  for (genvar k = 0; k < SpeedW; k++) begin : g_cell
    kls_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_w[k]),
      .rem_i   (rem_w[k]),
      .root_i  (root_w[k]),
      .rad_i   (rad_w[k]),
      .side_i  (side_w[k]),
      .valid_o (valid_w[k+1]),
      .rem_o   (rem_w[k+1]),
      .root_o  (root_w[k+1]),
      .rad_o   (rad_w[k+1]),
      .side_o  (side_w[k+1])
    );
  end

  assign valid_o = valid_w[SpeedW];
  assign root_o  = root_w[SpeedW];
  assign side_o  = side_w[SpeedW];

endmodule
`default_nettype wire

FILE: src/kls_decel_cell.sv
// ----------------------------------------------------------------------------
// kls_decel_cell: deceleration pick and radicand build for one refinement.
// The first register holds the deceleration, the second vt^2 + 2*a*d.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kls_decel_cell
  import kls_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [SpeedW-1:0] speed_i,
  input  wire kls_side_t         side_i,
  output logic                   valid_o,
  output logic [RadW-1:0]        rad_o,
  output kls_side_t              side_o
);

  localparam logic [SpeedW-1:0] FastLimit = 20'd61440;
  localparam logic [DecelW-1:0] FastDecel = 14'd2560;

  logic [21:0]       lin;
  logic [37:0]       lin_prod;
  logic [DecelW-1:0] acc_d;
  kls_side_t         side1_d;
  logic              v1_q;
  kls_side_t         side1_q;
  logic [33:0]       ad_prod;
  logic              v2_q;
  logic [RadW-1:0]   rad_q;
  kls_side_t         side2_q;

  // Speeds here never fall below 220, so only the two upper bands apply.
  assign lin      = 22'(3 * speed_i) + 22'd55296;
  assign lin_prod = lin * 16'd52429;
  assign acc_d    = (speed_i > FastLimit) ? FastDecel : lin_prod[33:20];
  assign ad_prod  = side1_q.acc * side1_q.pass_len;

  always_comb begin
    side1_d     = side_i;
    side1_d.acc = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      side2_q <= side1_q;
      rad_q   <= band_vt2(side1_q.band) + {1'b0, ad_prod, 5'b0};
    end
  end

  assign valid_o = v2_q;
  assign rad_o   = rad_q;
  assign side_o  = side2_q;

endmodule
`default_nettype wire
